/* rtl/pctc_pkg.sv */
// ----------------------------------------------------------------------------
// pctc_pkg
// Shared constants, codes and types of the prefix code table codec.
// ----------------------------------------------------------------------------
package pctc_pkg;

  localparam int MAX_LEN      = 32;
  localparam int SYMBOL_COUNT = 256;

  localparam int CODE_W  = 32;
  localparam int LEN_W   = 6;
  localparam int SYM_W   = 8;
  localparam int EFF_LEN = (MAX_LEN < CODE_W) ? MAX_LEN : CODE_W;
  localparam int IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int CNT_W   = $clog2(EFF_LEN + 1);

  typedef enum logic [1:0] {
    FN_LOAD    = 2'd0,
    FN_ENCODE  = 2'd1,
    FN_DECODE  = 2'd2,
    FN_RESTART = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_GIVEN    = 2'd0,
    STAT_DECODED  = 2'd1,
    STAT_NOCODE   = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ENC,
    ST_SCAN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              ok;
  } tbl_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              ok;
  } tbl_rdata_t;

  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [SYM_W-1:0]  sym;
  } res_t;

  // ones in the low len bits; a length of the full width or more gives all ones
  function automatic logic [CODE_W-1:0] low_mask(input logic [LEN_W-1:0] len);
    low_mask = ~({CODE_W{1'b1}} << len);
  endfunction

endpackage

/* rtl/pctc_item_if.sv */
// ----------------------------------------------------------------------------
// pctc_item_if
// Input channel of the codec: one command word per handshake.
// ----------------------------------------------------------------------------
interface pctc_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] symbol_in;
  logic [31:0] entry_code;
  logic [5:0] entry_length;
  logic       code_bit;

  modport source (
    output valid, func, symbol_in, entry_code, entry_length, code_bit,
    input  ready
  );
  modport sink (
    input  valid, func, symbol_in, entry_code, entry_length, code_bit,
    output ready
  );
endinterface

/* rtl/pctc_result_if.sv */
// ----------------------------------------------------------------------------
// pctc_result_if
// Output channel of the codec: one result word per handshake.
// ----------------------------------------------------------------------------
interface pctc_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] code_out;
  logic [5:0]  code_length_out;
  logic [7:0]  symbol_out;

  modport source (
    output valid, status, code_out, code_length_out, symbol_out,
    input  ready
  );
  modport sink (
    input  valid, status, code_out, code_length_out, symbol_out,
    output ready
  );
endinterface

/* rtl/pctc_table.sv */
// ----------------------------------------------------------------------------
// pctc_table
// Code table: code and length memories with one registered read port, and a
// valid bit per entry cleared by reset.
// ----------------------------------------------------------------------------
module pctc_table (
  input  logic                 clk,
  input  logic                 rst,
  input  pctc_pkg::tbl_wr_t    wr,
  input  pctc_pkg::tbl_rd_t    rd,
  output pctc_pkg::tbl_rdata_t rdata
);

  logic [pctc_pkg::CODE_W-1:0]       code_mem [pctc_pkg::SYMBOL_COUNT];
  logic [pctc_pkg::LEN_W-1:0]        len_mem  [pctc_pkg::SYMBOL_COUNT];
  logic [pctc_pkg::SYMBOL_COUNT-1:0] valid_bits;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      code_mem[wr.addr] <= wr.code;
      len_mem[wr.addr]  <= wr.len;
    end
    if (rd.en) begin
      rdata.code <= code_mem[rd.addr];
      rdata.len  <= len_mem[rd.addr];
      rdata.ok   <= valid_bits[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
    end else if (wr.en) begin
      valid_bits[wr.addr] <= wr.ok;
    end
  end

endmodule

/* rtl/pctc_ctrl.sv */
// ----------------------------------------------------------------------------
// pctc_ctrl
// Sequencer, bit accumulator and the shared compare unit that walks the table
// one entry a cycle for each decoded bit.
// ----------------------------------------------------------------------------
module pctc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  pctc_item_if.sink            item,
  output pctc_pkg::tbl_wr_t    wr,
  output pctc_pkg::tbl_rd_t    rd,
  input  pctc_pkg::tbl_rdata_t rdata,
  output pctc_pkg::res_t       res,
  input  logic                 take
);

  localparam logic [pctc_pkg::IDX_W-1:0] LAST_IDX =
    pctc_pkg::IDX_W'(pctc_pkg::SYMBOL_COUNT - 1);

  pctc_pkg::state_t state, state_next;
  pctc_pkg::func_t  func;

  logic [pctc_pkg::CODE_W-1:0] acc;
  logic [pctc_pkg::CNT_W-1:0]  acc_count;
  logic [pctc_pkg::IDX_W-1:0]  scan_idx;
  logic [pctc_pkg::IDX_W-1:0]  cmp_idx;
  logic                        issue_done;
  logic                        cmp_live;
  logic                        enc_ok;
  logic                        accept;
  logic                        sym_ok;
  logic                        len_ok;
  logic                        hit;
  logic                        scan_end;
  logic                        overflow;

  pctc_pkg::status_t              pend_status;
  logic [pctc_pkg::CODE_W-1:0]    pend_code;
  logic [pctc_pkg::LEN_W-1:0]     pend_len;
  logic [pctc_pkg::SYM_W-1:0]     pend_sym;

  assign func   = pctc_pkg::func_t'(item.func);
  assign accept = item.valid && item.ready;
  assign sym_ok = {1'b0, item.symbol_in} < (pctc_pkg::SYM_W + 1)'(pctc_pkg::SYMBOL_COUNT);
  assign len_ok = (item.entry_length != '0) &&
                  (item.entry_length <= pctc_pkg::LEN_W'(pctc_pkg::EFF_LEN));

  // shared compare unit: one stored entry against the accumulator
  assign hit = cmp_live && rdata.ok &&
               (rdata.len == pctc_pkg::LEN_W'(acc_count)) && (rdata.code == acc);
  assign scan_end = cmp_live && (cmp_idx == LAST_IDX);
  assign overflow = acc_count >= pctc_pkg::CNT_W'(pctc_pkg::EFF_LEN);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pctc_pkg::ST_IDLE: begin
        if (accept && func == pctc_pkg::FN_ENCODE) begin
          state_next = pctc_pkg::ST_ENC;
        end else if (accept && func == pctc_pkg::FN_DECODE) begin
          state_next = pctc_pkg::ST_SCAN;
        end
      end
      pctc_pkg::ST_ENC: begin
        state_next = pctc_pkg::ST_EMIT;
      end
      pctc_pkg::ST_SCAN: begin
        priority if (hit) begin
          state_next = pctc_pkg::ST_EMIT;
        end else if (scan_end) begin
          state_next = overflow ? pctc_pkg::ST_EMIT : pctc_pkg::ST_IDLE;
        end else begin
          state_next = pctc_pkg::ST_SCAN;
        end
      end
      pctc_pkg::ST_EMIT: begin
        if (take) begin
          state_next = pctc_pkg::ST_IDLE;
        end
      end
      default: state_next = pctc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    item.ready = 1'b0;
    wr         = '0;
    rd         = '0;
    res        = '0;
    unique case (state)
      pctc_pkg::ST_IDLE: begin
        item.ready = 1'b1;
        wr.en      = accept && (func == pctc_pkg::FN_LOAD) && sym_ok;
        wr.addr    = item.symbol_in[pctc_pkg::IDX_W-1:0];
        wr.len     = item.entry_length;
        wr.ok      = len_ok;
        wr.code    = len_ok ? (item.entry_code & pctc_pkg::low_mask(item.entry_length)) : '0;
        rd.en      = accept && (func == pctc_pkg::FN_ENCODE);
        rd.addr    = item.symbol_in[pctc_pkg::IDX_W-1:0];
      end
      pctc_pkg::ST_ENC: begin
        rd = '0;
      end
      pctc_pkg::ST_SCAN: begin
        rd.en   = !issue_done;
        rd.addr = scan_idx;
      end
      pctc_pkg::ST_EMIT: begin
        res.valid  = 1'b1;
        res.status = pend_status;
        res.code   = pend_code;
        res.len    = pend_len;
        res.sym    = pend_sym;
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pctc_pkg::ST_IDLE;
      acc        <= '0;
      acc_count  <= '0;
      issue_done <= 1'b0;
      cmp_live   <= 1'b0;
    end else begin
      state    <= state_next;
      cmp_live <= rd.en && (state == pctc_pkg::ST_SCAN);
      if (state == pctc_pkg::ST_IDLE && accept) begin
        if (func == pctc_pkg::FN_DECODE) begin
          acc        <= {acc[pctc_pkg::CODE_W-2:0], item.code_bit};
          acc_count  <= acc_count + 1'b1;
          issue_done <= 1'b0;
        end else if (func == pctc_pkg::FN_RESTART) begin
          acc       <= '0;
          acc_count <= '0;
        end
      end
      if (state == pctc_pkg::ST_SCAN) begin
        if (!issue_done && scan_idx == LAST_IDX) begin
          issue_done <= 1'b1;
        end
        // drop the accumulated bits on a match or an overflow
        if (state_next == pctc_pkg::ST_EMIT) begin
          acc       <= '0;
          acc_count <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == pctc_pkg::ST_IDLE) begin
      scan_idx <= '0;
      enc_ok   <= sym_ok;
    end else if (state == pctc_pkg::ST_SCAN && !issue_done) begin
      scan_idx <= scan_idx + 1'b1;
    end
    cmp_idx <= scan_idx;

    if (state == pctc_pkg::ST_ENC) begin
      pend_sym <= '0;
      if (enc_ok && rdata.ok) begin
        pend_status <= pctc_pkg::STAT_GIVEN;
        pend_code   <= rdata.code;
        pend_len    <= rdata.len;
      end else begin
        pend_status <= pctc_pkg::STAT_NOCODE;
        pend_code   <= '0;
        pend_len    <= '0;
      end
    end else if (state == pctc_pkg::ST_SCAN) begin
      pend_code   <= '0;
      pend_len    <= '0;
      pend_status <= hit ? pctc_pkg::STAT_DECODED : pctc_pkg::STAT_OVERFLOW;
      pend_sym    <= hit ? pctc_pkg::SYM_W'(cmp_idx) : '0;
    end
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    acc_count <= pctc_pkg::CNT_W'(pctc_pkg::EFF_LEN))
    else $error("accumulated count past maximum code length");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    (state == pctc_pkg::ST_SCAN && state_next == pctc_pkg::ST_EMIT) |=> (acc_count == '0))
    else $error("accumulator not cleared after match or overflow");

  a_cmp_follows_issue: assert property (@(posedge clk) disable iff (rst)
    cmp_live |-> (cmp_idx == $past(scan_idx) && $past(rd.en)))
    else $error("compare stage out of step with table read");

  a_write_only_on_load: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (accept && func == pctc_pkg::FN_LOAD))
    else $error("table write without a load word");
`endif

endmodule

/* rtl/prefix_code_table_codec.sv */
// ----------------------------------------------------------------------------
// prefix_code_table_codec
// Prefix code table for byte symbols: loads entries, encodes a symbol by
// direct lookup and decodes one received bit at a time against the table.
//
//   channel  | dir | words
//   ---------+-----+-----------------------------------------------------------
//   item     | in  | func, symbol_in, entry_code, entry_length, code_bit
//   result   | out | status, code_out, code_length_out, symbol_out
//
// Encode runs in order: table read, result build, hand-off to the output
// register. A decode bit walks the table through the single compare unit,
// one entry a cycle, and gives a result only on a match or an overflow.
// Reset (rst, synchronous) clears the valid bits, the accumulator and the
// sequencer. A result waiting in the output register does not block the
// next word; the sequencer holds only when a new result is ready and the
// register is still full.
// ----------------------------------------------------------------------------
module prefix_code_table_codec (
  input  logic           clk,
  input  logic           rst,
  pctc_item_if.sink      item,
  pctc_result_if.source  result
);

  pctc_pkg::tbl_wr_t    wr;
  pctc_pkg::tbl_rd_t    rd;
  pctc_pkg::tbl_rdata_t rdata;
  pctc_pkg::res_t       res;
  logic                 take;

  pctc_table u_table (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata)
  );

  pctc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .wr    (wr),
    .rd    (rd),
    .rdata (rdata),
    .res   (res),
    .take  (take)
  );

  // output register: load when empty or being drained
  assign take = res.valid && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.status          <= res.status;
      result.code_out        <= res.code;
      result.code_length_out <= res.len;
      result.symbol_out      <= res.sym;
    end
  end

endmodule
